FILE: src/b64d_pkg.sv
// shared types, constants and the alphabet lookup for the base64 stream decoder
// no dependencies; used by every module of the block
package b64d_pkg;

    localparam logic [7:0] PadChar = 8'h3D;

    localparam logic [1:0] StOk  = 2'd0;
    localparam logic [1:0] StLen = 2'd1;
    localparam logic [1:0] StBad = 2'd2;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_run;
        logic       end_of_message;
        logic [1:0] status;
    } t_out_beat;

    // one unit of work for the back end: up to three bytes of a quartet
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  count;
        logic        last;
        logic [1:0]  status;
    } t_job;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.bad   = 1'b0;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.value = 6'd63;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

FILE: src/b64d_front.sv
// front end: takes characters, maps them to sextets and packs quartets into jobs
// depends on b64d_pkg
module b64d_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  b64d_pkg::t_in_beat i_beat,
    output logic               o_push,
    output b64d_pkg::t_job     o_job
);

    logic [1:0]  r_pos;
    logic [17:0] r_acc;
    logic        r_third_pad;
    logic        r_bad;

    b64d_pkg::t_sextet w_sx;
    logic        w_is_pad;
    logic        w_bad_now;
    logic [5:0]  w_val;
    logic        w_last;
    logic [1:0]  w_drop;

    assign w_sx      = b64d_pkg::sextet_of(i_beat.char_code);
    assign w_is_pad  = (i_beat.char_code == b64d_pkg::PadChar);
    assign w_bad_now = !w_is_pad && w_sx.bad;
    assign w_val     = (w_is_pad || w_sx.bad) ? 6'd0 : w_sx.value;
    assign w_last    = i_beat.end_of_text;
    assign w_drop    = {1'b0, w_last && w_is_pad} + {1'b0, w_last && r_third_pad};

    always_comb begin
        o_push = i_accept && ((r_pos == 2'd3) || w_last);
        o_job  = '0;
        if (r_pos == 2'd3) begin
            o_job.triple = {r_acc, w_val};
            o_job.count  = 2'd3 - w_drop;
            o_job.last   = w_last;
            o_job.status = (r_bad || w_bad_now) ? b64d_pkg::StBad : b64d_pkg::StOk;
        end else begin
            // short message: one zero byte carrying the length error
            o_job.triple = 24'd0;
            o_job.count  = 2'd1;
            o_job.last   = 1'b1;
            o_job.status = b64d_pkg::StLen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 2'd0;
            r_acc       <= 18'd0;
            r_third_pad <= 1'b0;
            r_bad       <= 1'b0;
        end else if (i_accept) begin
            if (r_pos == 2'd3 || w_last) begin
                r_pos       <= 2'd0;
                r_acc       <= 18'd0;
                r_third_pad <= 1'b0;
                r_bad       <= 1'b0;
            end else begin
                r_acc <= {r_acc[11:0], w_val};
                r_pos <= r_pos + 2'd1;
                r_bad <= r_bad || w_bad_now;
                if (r_pos == 2'd2) begin
                    r_third_pad <= w_is_pad;
                end
            end
        end
    end

    a_short_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_last && r_pos != 2'd3) |=> (r_pos == 2'd0 && !r_bad))
        else $error("length error did not clear quartet state");

endmodule

FILE: src/b64d_queue.sv
// short job queue between the front and back ends
// depends on b64d_pkg
module b64d_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output b64d_pkg::t_job o_head
);

    b64d_pkg::t_job r_mem [b64d_pkg::QDepth];
    logic [b64d_pkg::QPtrW-1:0] r_wr;
    logic [b64d_pkg::QPtrW-1:0] r_rd;
    logic [b64d_pkg::QPtrW:0]   r_count;

    assign o_full  = (r_count == (b64d_pkg::QPtrW + 1)'(b64d_pkg::QDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job queue underflow");

endmodule

FILE: src/b64d_back.sv
// back end: splits each job into bytes and holds them in the output register
// depends on b64d_pkg
module b64d_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  b64d_pkg::t_job      i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b64d_pkg::t_out_beat o_out_data
);

    logic [1:0]          r_idx;
    logic                r_valid;
    b64d_pkg::t_out_beat r_data;

    logic                w_load;
    logic                w_final;
    logic [7:0]          w_byte;

    assign w_load  = !i_empty && (!r_valid || i_out_ready);
    assign w_final = (r_idx == i_head.count - 2'd1);
    assign o_pop   = w_load && w_final;

    always_comb begin
        case (r_idx)
            2'd0:    w_byte = i_head.triple[23:16];
            2'd1:    w_byte = i_head.triple[15:8];
            default: w_byte = i_head.triple[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_final ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data.data_byte      <= w_byte;
            r_data.last_of_run    <= w_final;
            r_data.end_of_message <= w_final && i_head.last;
            r_data.status         <= i_head.status;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < i_head.count))
        else $error("byte index ran past the job");

endmodule

FILE: src/base64_stream_decoder.sv
// Base64 stream decoder: takes one character per beat and returns up to three
// bytes per quartet, with padding, length-error and bad-character status.
// Characters are accepted one per cycle: the front end forms a quartet's job
// combinationally on its fourth character and hands it to a four-entry queue.
// Unless the receiver stalls, the back end sends one byte per cycle from its
// output register, so a quartet (three bytes per four characters) keeps pace;
// in_ready drops only when the queue is full, which happens only after the
// output side stalls; jobs wait in the queue ahead of the output register.
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
module base64_stream_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  b64d_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b64d_pkg::t_out_beat o_out_data
);

    logic           w_accept;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    b64d_pkg::t_job w_job;
    b64d_pkg::t_job w_head;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_beat  (i_in_data),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    b64d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

FILE: sim/b64d_checker.sv
// checker for the base64 stream decoder: predicts every output beat from the
// accepted input beats and compares each accepted output beat field by field
// depends on b64d_pkg
module b64d_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  b64d_pkg::t_in_beat  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  b64d_pkg::t_out_beat i_out_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_bytes_checked,
    output int                  o_len_errors,
    output int                  o_bad_bytes
);

    import b64d_pkg::*;

    t_out_beat   expected_bytes[$];
    t_out_beat   want;

    logic [1:0]  quartet_pos;
    logic [17:0] sextet_acc;
    logic        pad_in_third;
    logic        bad_in_quartet;

    int fail_count    = 0;
    int pending_count = 0;
    int bytes_checked = 0;
    int len_errors    = 0;
    int bad_bytes     = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_count;
    assign o_bytes_checked = bytes_checked;
    assign o_len_errors    = len_errors;
    assign o_bad_bytes     = bad_bytes;

    // bit 6 flags a byte outside the alphabet, value bits are then zero
    function automatic logic [6:0] alphabet_value(input logic [7:0] c);
        if (c == 8'h2B) begin
            return 7'd62;
        end
        if (c == 8'h2F) begin
            return 7'd63;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            return 7'(c - 8'h30 + 8'd52);
        end
        if (c >= 8'h41 && c <= 8'h5A) begin
            return 7'(c - 8'h41);
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            return 7'(c - 8'h61 + 8'd26);
        end
        return 7'h40;
    endfunction

    task automatic clear_quartet();
        quartet_pos    = 2'd0;
        sextet_acc     = 18'd0;
        pad_in_third   = 1'b0;
        bad_in_quartet = 1'b0;
    endtask

    task automatic decode_char(input t_in_beat beat);
        logic [6:0]  lookup;
        logic [5:0]  six;
        logic        is_pad;
        logic [23:0] triple;
        logic [1:0]  quartet_status;
        int          nbytes;
        t_out_beat   b;
        is_pad = (beat.char_code == PadChar);
        lookup = alphabet_value(beat.char_code);
        six    = is_pad ? 6'd0 : lookup[5:0];
        if (!is_pad && lookup[6]) begin
            bad_in_quartet = 1'b1;
        end
        if (quartet_pos != 2'd3) begin
            if (beat.end_of_text) begin
                // message ended mid quartet: one length-error beat only
                b.data_byte      = 8'h00;
                b.last_of_run    = 1'b1;
                b.end_of_message = 1'b1;
                b.status         = StLen;
                expected_bytes.push_back(b);
                clear_quartet();
            end else begin
                sextet_acc = {sextet_acc[11:0], six};
                if (quartet_pos == 2'd2) begin
                    pad_in_third = is_pad;
                end
                quartet_pos = quartet_pos + 2'd1;
            end
        end else begin
            triple         = {sextet_acc, six};
            quartet_status = bad_in_quartet ? StBad : StOk;
            nbytes         = 3;
            // padding only trims the closing quartet
            if (beat.end_of_text) begin
                nbytes = nbytes - int'(is_pad) - int'(pad_in_third);
            end
            for (int k = 0; k < nbytes; k++) begin
                b.data_byte      = triple[23 - 8 * k -: 8];
                b.last_of_run    = (k == nbytes - 1);
                b.end_of_message = beat.end_of_text && (k == nbytes - 1);
                b.status         = quartet_status;
                expected_bytes.push_back(b);
            end
            clear_quartet();
        end
    endtask

    task automatic report_field(input string field, input int unsigned exp_val,
                                input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bytes.delete();
            clear_quartet();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: output beat with nothing expected: expected none, actual 0x%0h",
                             $time, i_out_data);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    report_field("data_byte", want.data_byte, i_out_data.data_byte);
                    report_field("last_of_run", want.last_of_run, i_out_data.last_of_run);
                    report_field("end_of_message", want.end_of_message,
                                 i_out_data.end_of_message);
                    report_field("status", want.status, i_out_data.status);
                    bytes_checked++;
                    if (want.status == StLen) begin
                        len_errors++;
                    end
                    if (want.status == StBad) begin
                        bad_bytes++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_char(i_in_data);
            end
        end
        pending_count <= expected_bytes.size();
    end

endmodule

FILE: sim/tb_base64_stream_decoder.sv
// testbench top for the base64 stream decoder: clock, reset, character stimulus
// and a stalling receiver; depends on b64d_pkg, b64d_checker and the decoder
module tb_base64_stream_decoder;

    import b64d_pkg::*;

    localparam int ClkPeriod   = 12;
    localparam int ResetCycles = 9;
    localparam int RandomChars = 250;
    localparam int DrainCycles = 20;
    localparam int CycleLimit  = 200000;

    typedef enum {RxOpen, RxCoin, RxThreeOfFour, RxTrickle} t_rx_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    int fail_count;
    int pending;
    int bytes_checked;
    int len_errors;
    int bad_bytes;

    t_in_beat text_chars[$];
    int       message_count = 0;
    int       cycle_count   = 0;

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    base64_stream_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    b64d_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_data     (o_out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_bytes_checked(bytes_checked),
        .o_len_errors   (len_errors),
        .o_bad_bytes    (bad_bytes)
    );

    task automatic add_char(input logic [7:0] c, input logic eot);
        t_in_beat t;
        t.char_code   = c;
        t.end_of_text = eot;
        text_chars.push_back(t);
        if (eot) begin
            message_count++;
        end
    endtask

    task automatic add_text(input string s, input logic close_msg);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i], close_msg && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] random_alpha();
        int idx;
        idx = $urandom_range(0, 63);
        if (idx < 26) begin
            return 8'(8'h41 + idx);
        end
        if (idx < 52) begin
            return 8'(8'h61 + idx - 26);
        end
        if (idx < 62) begin
            return 8'(8'h30 + idx - 52);
        end
        return (idx == 62) ? 8'h2B : 8'h2F;
    endfunction

    task automatic add_random_message();
        int         kind;
        int         quads;
        int         pad_style;
        int         nchars;
        logic [7:0] c;
        logic       pad_here;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            // well-formed text, a sprinkle of bad bytes and stray padding
            quads     = $urandom_range(1, 4);
            pad_style = $urandom_range(0, 3);
            for (int q = 0; q < quads; q++) begin
                for (int p = 0; p < 4; p++) begin
                    c = random_alpha();
                    if ($urandom_range(0, 39) == 0) begin
                        c = 8'($urandom_range(0, 255));
                    end else if ($urandom_range(0, 39) == 0) begin
                        c = PadChar;
                    end
                    // pad styles: none, fourth, third and fourth, third only
                    pad_here = (p == 3 && (pad_style == 1 || pad_style == 2)) ||
                               (p == 2 && (pad_style == 2 || pad_style == 3));
                    if (q == quads - 1 && pad_here) begin
                        c = PadChar;
                    end
                    add_char(c, (q == quads - 1) && (p == 3));
                end
            end
        end else if (kind < 88) begin
            // truncated text, always a length error
            nchars = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
            for (int i = 0; i < nchars; i++) begin
                c = ($urandom_range(0, 9) == 0) ? PadChar : random_alpha();
                add_char(c, i == nchars - 1);
            end
        end else begin
            nchars = $urandom_range(1, 8);
            for (int i = 0; i < nchars; i++) begin
                add_char(8'($urandom_range(0, 255)), i == nchars - 1);
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, pending);
            $display("base64_stream_decoder regression: fail");
            $finish;
        end
    end

    // receiver: shifting stall patterns plus two long hold-offs
    initial begin
        int       rx_cycle;
        int       stall_left;
        t_rx_mode mode;
        rx_cycle    = 0;
        stall_left  = 0;
        mode        = RxOpen;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle % 40 == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
            end
            if (rx_cycle == 160 || rx_cycle == 420) begin
                stall_left = 90;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    RxOpen:        i_out_ready <= 1'b1;
                    RxCoin:        i_out_ready <= 1'($urandom_range(0, 1));
                    RxThreeOfFour: i_out_ready <= (rx_cycle % 4 != 0);
                    default:       i_out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin
        int idx;
        int burst;
        int gap;
        int directed_chars;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;

        // interior quartet with pad, then a closing quartet keeping one byte
        add_text("+9z=", 1'b0);
        add_text("Mw==", 1'b1);
        // pad in third position only still drops a byte
        add_text("Zm=v", 1'b1);
        // padding in a non-final quartet, then a closing quartet with one pad
        add_text("==//", 1'b0);
        add_text("Zm9=", 1'b1);
        // bytes outside the alphabet, extremes of the field
        add_char(8'h00, 1'b0);
        add_char(8'h2A, 1'b0);
        add_char(8'h41, 1'b0);
        add_char(8'hFF, 1'b1);
        // length errors, one of them over a bad byte
        add_text("A", 1'b1);
        add_text("*BC", 1'b1);
        directed_chars = text_chars.size();
        while (text_chars.size() - directed_chars < RandomChars) begin
            add_random_message();
        end

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idx = 0;
        while (idx < text_chars.size()) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && idx < text_chars.size()) begin
                i_in_valid <= 1'b1;
                i_in_data  <= text_chars[idx];
                @(posedge i_clk);
                while (!o_in_ready) @(posedge i_clk);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("sent %0d characters in %0d messages (%0d directed characters)",
                 text_chars.size(), message_count, directed_chars);
        $display("checked %0d output beats: %0d length errors, %0d bad-character bytes",
                 bytes_checked, len_errors, bad_bytes);
        if (pending != 0) begin
            $display("%0d expected bytes never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("base64_stream_decoder regression: pass");
        end else begin
            $display("base64_stream_decoder regression: fail");
        end
        $finish;
    end

endmodule
